>>> rtl/assert_macros.svh
// assertion macros shared by the pattern remover rtl
// no dependencies; define SYNTH to compile the checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property that must hold at every clock edge out of reset
`define POR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// same-cycle implication
`define POR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define POR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define POR_ASSERT(lbl, clk, rstn, prop, msg)
`define POR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define POR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

>>> rtl/por_pkg.sv
// shared constants and types of the pattern occurrence remover
// no dependencies
package por_pkg;

    localparam int PAT_MAX   = 16;
    localparam int WORD_BITS = 32;
    localparam int LEN_W     = 5;
    localparam int PIDX_W    = 4;
    localparam int COUNT_W   = $clog2(PAT_MAX + 1);
    localparam int IDX_W     = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;

    // item function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TEXT = 1'b1;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic [COUNT_W-1:0]          count_t;
    typedef logic [IDX_W-1:0]            idx_t;

    // window control from the sequencer
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } win_ctrl_t;

endpackage

>>> rtl/por_window.sv
// pending window of text words: shift register with fill count
// depends on por_pkg and assert_macros.svh
`include "assert_macros.svh"

module por_window (
    input  logic                aclk,
    input  logic                aresetn,
    input  por_pkg::win_ctrl_t  ctrl,
    input  por_pkg::word_t      push_data,
    input  por_pkg::idx_t       rd_idx,
    output por_pkg::word_t      rd_data,
    output por_pkg::word_t      head_data,
    output por_pkg::count_t     count
);

    por_pkg::word_t  win_reg [por_pkg::PAT_MAX];
    por_pkg::count_t count_reg;
    por_pkg::count_t count_next;
    logic            has_room;

    assign has_room  = (count_reg < por_pkg::count_t'(por_pkg::PAT_MAX));
    assign rd_data   = win_reg[rd_idx];
    assign head_data = win_reg[0];
    assign count     = count_reg;

    // fill count, clear has priority
    always_comb begin
        count_next = count_reg;
        if (ctrl.clear) begin
            count_next = '0;
        end else if (ctrl.push && has_room) begin
            count_next = count_reg + por_pkg::count_t'(1);
        end else if (ctrl.pop && count_reg != '0) begin
            count_next = count_reg - por_pkg::count_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // word storage: append at the fill point, shift toward the head on pop
    always_ff @(posedge aclk) begin
        if (ctrl.push && has_room) begin
            win_reg[count_reg[por_pkg::IDX_W-1:0]] <= push_data;
        end else if (ctrl.pop) begin
            for (int i = 0; i < por_pkg::PAT_MAX - 1; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
        end
    end

    `POR_ASSERT(a_count_bound, aclk, aresetn, count_reg <= por_pkg::count_t'(por_pkg::PAT_MAX), "window count beyond depth")
    `POR_ASSERT(a_push_pop_excl, aclk, aresetn, !(ctrl.push && ctrl.pop), "push and pop in one cycle")
    `POR_ASSERT_IMP(a_pop_nonempty, aclk, aresetn, ctrl.pop && !ctrl.clear, count_reg != '0, "pop from empty window")

endmodule

>>> rtl/pattern_occurrence_remover_core.sv
// top level of the pattern occurrence remover: sequencer, pattern store, output register
// depends on por_pkg, por_window and assert_macros.svh
`include "assert_macros.svh"

// Removes every non-overlapping occurrence of a stored pattern (up to 16 words)
// from a text stream, left to right. A pattern load (func 0) is written to the
// pattern store on accept, and the sequencer stays idle. A text word (func 1) is
// pushed into the window on accept, then compared word by word by the single
// shared comparator (up to pattern_length, stopping at the first mismatch);
// a decision step follows, and the kept words leave one by one through the
// output register (held while m_ready is low). An end-of-text word with
// nothing to emit ends with a bare end marker. s_ready is high only while the
// sequencer is idle. pattern_length is taken from cfg_wr_data when cfg_wr_en
// is high, and must only change while the block is idle; values above 16 act as 16.

module pattern_occurrence_remover_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration
    input  logic                        cfg_wr_en,
    input  logic [por_pkg::LEN_W-1:0]   cfg_wr_data,
    // input channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_func,
    input  logic [por_pkg::PIDX_W-1:0]  s_pattern_index,
    input  por_pkg::word_t              s_word,
    input  logic                        s_end_of_text,
    // result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output por_pkg::word_t              m_out_word,
    output logic                        m_word_valid,
    output logic                        m_last_of_text
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_EMIT,
        ST_MARK
    } state_t;

    state_t                     state_reg,  state_next;
    por_pkg::count_t            len_reg,    len_next;
    por_pkg::count_t            cmp_idx_reg, cmp_idx_next;
    por_pkg::count_t            emit_cnt_reg, emit_cnt_next;
    logic                       match_reg,  match_next;
    logic                       eot_reg,    eot_next;
    logic                       drop_reg,   drop_next;
    logic                       m_valid_reg, m_valid_next;
    por_pkg::word_t             m_out_word_reg, m_out_word_next;
    logic                       m_word_valid_reg, m_word_valid_next;
    logic                       m_last_of_text_reg, m_last_of_text_next;
    logic [por_pkg::LEN_W-1:0]  pattern_length_reg;

    por_pkg::word_t             pattern_store_reg [por_pkg::PAT_MAX];

    por_pkg::win_ctrl_t         win_ctrl;
    por_pkg::word_t             win_rd_data;
    por_pkg::word_t             win_head;
    por_pkg::count_t            win_count;
    por_pkg::idx_t              win_rd_idx;

    por_pkg::count_t            len_clamped;
    por_pkg::count_t            base;
    por_pkg::count_t            rd_pos;
    por_pkg::count_t            emit_n;
    logic                       cmp_en;
    logic                       cmp_active;
    logic                       elem_eq;
    logic                       is_match;
    logic                       out_free;
    logic                       in_xfer;

    assign s_ready        = (state_reg == ST_IDLE);
    assign in_xfer        = s_valid && s_ready;
    assign m_valid        = m_valid_reg;
    assign m_out_word     = m_out_word_reg;
    assign m_word_valid   = m_word_valid_reg;
    assign m_last_of_text = m_last_of_text_reg;
    assign out_free       = !m_valid_reg || m_ready;

    // pending window
    por_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (win_ctrl),
        .push_data (s_word),
        .rd_idx    (win_rd_idx),
        .rd_data   (win_rd_data),
        .head_data (win_head),
        .count     (win_count)
    );

    // pattern length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_length_reg <= '0;
        end else if (cfg_wr_en) begin
            pattern_length_reg <= cfg_wr_data;
        end
    end

    // pattern store, written by load items
    always_ff @(posedge aclk) begin
        if (in_xfer && s_func == por_pkg::FUNC_LOAD
            && int'(s_pattern_index) < por_pkg::PAT_MAX) begin
            pattern_store_reg[por_pkg::idx_t'(s_pattern_index)] <= s_word;
        end
    end

    // window geometry and the shared comparator
    always_comb begin
        len_clamped = (int'(pattern_length_reg) > por_pkg::PAT_MAX)
                    ? por_pkg::count_t'(por_pkg::PAT_MAX)
                    : por_pkg::count_t'(pattern_length_reg);
        cmp_en      = (len_reg != '0) && (win_count >= len_reg);
        base        = win_count - len_reg;
        cmp_active  = cmp_en && (cmp_idx_reg < len_reg);
        rd_pos      = base + cmp_idx_reg;
        win_rd_idx  = rd_pos[por_pkg::IDX_W-1:0];
        elem_eq     = (win_rd_data
                       == pattern_store_reg[cmp_idx_reg[por_pkg::IDX_W-1:0]]);
        is_match    = cmp_en && match_reg;
        if (is_match) begin
            emit_n = base;
        end else if (eot_reg || len_reg == '0) begin
            emit_n = win_count;
        end else if (cmp_en) begin
            emit_n = base + por_pkg::count_t'(1);
        end else begin
            emit_n = '0;
        end
    end

    // sequencer next state
    always_comb begin
        state_next          = state_reg;
        len_next            = len_reg;
        cmp_idx_next        = cmp_idx_reg;
        emit_cnt_next       = emit_cnt_reg;
        match_next          = match_reg;
        eot_next            = eot_reg;
        drop_next           = drop_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        m_out_word_next     = m_out_word_reg;
        m_word_valid_next   = m_word_valid_reg;
        m_last_of_text_next = m_last_of_text_reg;
        win_ctrl            = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer && s_func == por_pkg::FUNC_TEXT) begin
                    win_ctrl.push = 1'b1;
                    len_next      = len_clamped;
                    eot_next      = s_end_of_text;
                    match_next    = 1'b1;
                    cmp_idx_next  = '0;
                    state_next    = ST_CMP;
                end
            end
            ST_CMP: begin
                if (cmp_active) begin
                    // one pattern word per cycle, stop early on a mismatch
                    match_next   = match_reg && elem_eq;
                    cmp_idx_next = elem_eq ? cmp_idx_reg + por_pkg::count_t'(1) : len_reg;
                end else begin
                    emit_cnt_next = emit_n;
                    drop_next     = is_match;
                    if (emit_n != '0) begin
                        state_next = ST_EMIT;
                    end else begin
                        win_ctrl.clear = is_match;
                        state_next     = eot_reg ? ST_MARK : ST_IDLE;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    m_out_word_next     = win_head;
                    m_word_valid_next   = 1'b1;
                    m_last_of_text_next = eot_reg && (emit_cnt_reg == por_pkg::count_t'(1));
                    win_ctrl.pop        = 1'b1;
                    emit_cnt_next       = emit_cnt_reg - por_pkg::count_t'(1);
                    if (emit_cnt_reg == por_pkg::count_t'(1)) begin
                        // matched run leaves the window with the last kept word
                        win_ctrl.clear = drop_reg;
                        state_next     = ST_IDLE;
                    end
                end
            end
            ST_MARK: begin
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    m_out_word_next     = '0;
                    m_word_valid_next   = 1'b0;
                    m_last_of_text_next = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        len_reg             <= len_next;
        cmp_idx_reg         <= cmp_idx_next;
        match_reg           <= match_next;
        eot_reg             <= eot_next;
        drop_reg            <= drop_next;
        m_out_word_reg      <= m_out_word_next;
        m_word_valid_reg    <= m_word_valid_next;
        m_last_of_text_reg  <= m_last_of_text_next;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            emit_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            emit_cnt_reg <= emit_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    `POR_ASSERT_IMP(a_marker_is_last, aclk, aresetn, m_valid_reg && !m_word_valid_reg, m_last_of_text_reg, "bare marker without last flag")
    `POR_ASSERT_NXT(a_text_fills_window, aclk, aresetn, in_xfer && s_func == por_pkg::FUNC_TEXT, win_count != '0, "text transfer left window empty")
    `POR_ASSERT_IMP(a_idle_no_emit, aclk, aresetn, state_reg == ST_IDLE, emit_cnt_reg == '0, "idle with words left to emit")
    `POR_ASSERT_IMP(a_cmp_in_window, aclk, aresetn, state_reg == ST_CMP && cmp_active, rd_pos < win_count, "compare reads past window fill")

endmodule

>>> test/pattern_occurrence_remover_core_tb.sv
// testbench for pattern_occurrence_remover_core: directed and random streams, checked
// against a behavioral predictor of the pattern removal
// depends on por_pkg and the rtl of the block
module pattern_occurrence_remover_core_tb;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_TEXTS   = 36;
    localparam por_pkg::word_t WORD_MAX = 32'sh7FFF_FFFF;
    localparam por_pkg::word_t WORD_MIN = 32'sh8000_0000;

    typedef logic [por_pkg::LEN_W-1:0]  len_t;
    typedef logic [por_pkg::PIDX_W-1:0] pidx_t;

    typedef struct packed {
        por_pkg::word_t out_word;
        logic           word_valid;
        logic           last_of_text;
    } kept_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    len_t                cfg_wr_data = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_func = por_pkg::FUNC_TEXT;
    pidx_t               s_pattern_index = '0;
    por_pkg::word_t      s_word = '0;
    logic                s_end_of_text = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    por_pkg::word_t      m_out_word;
    logic                m_word_valid;
    logic                m_last_of_text;

    // predictor state
    por_pkg::word_t   pattern_words [por_pkg::PAT_MAX];
    por_pkg::word_t   held_words [$];
    len_t             pattern_len = '0;
    kept_t            kept_words_due [$];

    int  mismatches = 0;
    int  cycle_count = 0;
    int  ready_stall = 0;
    bit  no_idle = 1'b0;
    kept_t due_word;

    pattern_occurrence_remover_core u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_pattern_index (s_pattern_index),
        .s_word          (s_word),
        .s_end_of_text   (s_end_of_text),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_word      (m_out_word),
        .m_word_valid    (m_word_valid),
        .m_last_of_text  (m_last_of_text)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("pattern_occurrence_remover_core_tb failed");
            $finish;
        end
    end

    // one text word through the removal window, queueing the words it releases
    function automatic void predict_removal(por_pkg::word_t w, logic eot);
        kept_t step_words [$];
        int    len;
        bit    same;
        len = (pattern_len > por_pkg::PAT_MAX) ? por_pkg::PAT_MAX : int'(pattern_len);
        if (held_words.size() < por_pkg::PAT_MAX)
            held_words.insert(held_words.size(), w);
        // words beyond the current length go out first
        while (held_words.size() > len)
            step_words.insert(step_words.size(),
                              kept_t'{held_words.pop_front(), 1'b1, 1'b0});
        if (len > 0 && held_words.size() == len) begin
            same = 1'b1;
            for (int i = 0; i < len; i++)
                if (held_words[i] !== pattern_words[i])
                    same = 1'b0;
            if (same)
                held_words.delete();
            else
                step_words.insert(step_words.size(),
                                  kept_t'{held_words.pop_front(), 1'b1, 1'b0});
        end
        if (eot) begin
            while (held_words.size() > 0)
                step_words.insert(step_words.size(),
                                  kept_t'{held_words.pop_front(), 1'b1, 1'b0});
            // nothing left to emit: bare end marker
            if (step_words.size() == 0)
                step_words.insert(0, kept_t'{por_pkg::word_t'(0), 1'b0, 1'b1});
            else
                step_words[step_words.size()-1].last_of_text = 1'b1;
        end
        foreach (step_words[i])
            kept_words_due.insert(kept_words_due.size(), step_words[i]);
    endfunction

    // result checking
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (kept_words_due.size() == 0) begin
                $error("unexpected result: out_word %0d", m_out_word);
                mismatches++;
            end else begin
                due_word = kept_words_due.pop_front();
                if (m_out_word !== due_word.out_word) begin
                    $error("out_word: expected %0d, got %0d", due_word.out_word, m_out_word);
                    mismatches++;
                end
                if (m_word_valid !== due_word.word_valid) begin
                    $error("word_valid: expected %0b, got %0b",
                           due_word.word_valid, m_word_valid);
                    mismatches++;
                end
                if (m_last_of_text !== due_word.last_of_text) begin
                    $error("last_of_text: expected %0b, got %0b",
                           due_word.last_of_text, m_last_of_text);
                    mismatches++;
                end
            end
            ready_stall = no_idle ? 0 : int'($urandom_range(0, 9));
        end
    end

    // receiver stalls
    always @(negedge aclk) begin
        if (ready_stall > 0) begin
            m_ready = 1'b0;
            ready_stall--;
        end else begin
            m_ready = 1'b1;
        end
    end

    // one input transfer; called at a falling edge, returns at a falling edge
    task automatic send_item(logic func, pidx_t idx, por_pkg::word_t w, logic eot);
        int gap;
        gap = no_idle ? 0 : int'($urandom_range(0, 9));
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid         = 1'b1;
        s_func          = func;
        s_pattern_index = idx;
        s_word          = w;
        s_end_of_text   = eot;
        do
            @(posedge aclk);
        while (s_ready !== 1'b1);
        if (func == por_pkg::FUNC_LOAD)
            pattern_words[idx] = w;
        else
            predict_removal(w, eot);
        @(negedge aclk);
    endtask

    // hold the sender until every due word has come and the block has settled
    task automatic wait_drained();
        s_valid = 1'b0;
        while (kept_words_due.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_pattern_length(len_t len);
        wait_drained();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = len;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        pattern_len = len;
    endtask

    function automatic por_pkg::word_t pick_symbol();
        case ($urandom_range(0, 3))
            0:       return por_pkg::word_t'(0);
            1:       return por_pkg::word_t'(-1);
            2:       return WORD_MAX;
            default: return WORD_MIN;
        endcase
    endfunction

    // zero length passes text unchanged
    task automatic test_passthrough();
        send_item(por_pkg::FUNC_TEXT, 4'hF, WORD_MAX, 1'b0);
        send_item(por_pkg::FUNC_TEXT, 4'h0, WORD_MIN, 1'b1);
    endtask

    // pattern max, min; end flag on a load is ignored
    task automatic test_pattern_load();
        send_item(por_pkg::FUNC_LOAD, 4'd0, WORD_MAX, 1'b1);
        send_item(por_pkg::FUNC_LOAD, 4'd1, WORD_MIN, 1'b0);
        send_item(por_pkg::FUNC_LOAD, 4'd15, por_pkg::word_t'(0), 1'b0);
        set_pattern_length(5'd2);
    endtask

    // removal, restart after a removed run, end flush and bare end marker
    task automatic test_match_removal();
        send_item(por_pkg::FUNC_TEXT, 4'd3, WORD_MAX, 1'b0);
        send_item(por_pkg::FUNC_TEXT, 4'd3, WORD_MIN, 1'b0);
        send_item(por_pkg::FUNC_TEXT, 4'd3, por_pkg::word_t'(-1), 1'b0);
        send_item(por_pkg::FUNC_TEXT, 4'd3, WORD_MAX, 1'b0);
        send_item(por_pkg::FUNC_TEXT, 4'd3, WORD_MAX, 1'b0);
        send_item(por_pkg::FUNC_TEXT, 4'd3, WORD_MIN, 1'b0);
        send_item(por_pkg::FUNC_TEXT, 4'd3, por_pkg::word_t'(7), 1'b1);
        send_item(por_pkg::FUNC_TEXT, 4'd3, WORD_MAX, 1'b0);
        send_item(por_pkg::FUNC_TEXT, 4'd3, WORD_MIN, 1'b1);
    endtask

    // a word held in the window when the length drops below it
    task automatic test_length_shrink();
        send_item(por_pkg::FUNC_TEXT, 4'd5, por_pkg::word_t'(-1), 1'b0);
        set_pattern_length(5'd1);
        send_item(por_pkg::FUNC_TEXT, 4'd5, WORD_MIN, 1'b1);
    endtask

    // pattern word rewritten between text words
    task automatic test_pattern_change();
        set_pattern_length(5'd2);
        send_item(por_pkg::FUNC_TEXT, 4'd9, WORD_MAX, 1'b0);
        send_item(por_pkg::FUNC_LOAD, 4'd1, por_pkg::word_t'(42), 1'b0);
        send_item(por_pkg::FUNC_TEXT, 4'd9, por_pkg::word_t'(42), 1'b0);
        send_item(por_pkg::FUNC_TEXT, 4'd9, por_pkg::word_t'(-5), 1'b1);
    endtask

    // random stream, half of its picks pattern copies, with noise and mid-text loads
    task automatic test_random_streams();
        int text_sent;
        int pick;
        int eff;
        int n;
        int spoil;
        len_t len;
        por_pkg::word_t w;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       len = 5'd16;
                1:       len = 5'd31;
                2:       len = 5'd17;
                3:       len = 5'd0;
                4:       len = 5'd1;
                default: len = ($urandom_range(0, 3) == 0) ? len_t'($urandom_range(0, 31))
                                                           : len_t'($urandom_range(1, 5));
            endcase
            set_pattern_length(len);
            no_idle = (phase % 4 == 3);
            eff = (len > por_pkg::PAT_MAX) ? por_pkg::PAT_MAX : int'(len);
            // each phase writes the first eff pattern entries; the first phase writes every one
            for (int i = 0; i < eff; i++)
                send_item(por_pkg::FUNC_LOAD, pidx_t'(i), pick_symbol(),
                          $urandom_range(0, 1) == 1);
            text_sent = 0;
            while (text_sent < PHASE_TEXTS) begin
                pick = int'($urandom_range(0, 11));
                if (pick <= 5 && eff > 0) begin
                    n = (pick == 5) ? int'($urandom_range(1, eff)) : eff;
                    spoil = (pick == 4) ? int'($urandom_range(0, n - 1)) : -1;
                    for (int i = 0; i < n; i++) begin
                        w = (i == spoil) ? ~pattern_words[i] : pattern_words[i];
                        send_item(por_pkg::FUNC_TEXT, pidx_t'($urandom_range(0, 15)), w,
                                  (i == n - 1) && ($urandom_range(0, 4) == 0));
                        text_sent++;
                    end
                end else if (pick <= 8) begin
                    send_item(por_pkg::FUNC_TEXT, pidx_t'($urandom_range(0, 15)),
                              pick_symbol(), $urandom_range(0, 5) == 0);
                    text_sent++;
                end else if (pick == 9) begin
                    send_item(por_pkg::FUNC_TEXT, pidx_t'($urandom_range(0, 15)),
                              por_pkg::word_t'($urandom), $urandom_range(0, 5) == 0);
                    text_sent++;
                end else if (pick == 10) begin
                    send_item(por_pkg::FUNC_LOAD, pidx_t'($urandom_range(0, 15)),
                              pick_symbol(), $urandom_range(0, 1) == 1);
                end else begin
                    wait_drained();
                end
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        test_passthrough();
        test_pattern_load();
        test_match_removal();
        test_length_shrink();
        test_pattern_change();
        test_random_streams();
        // flush whatever the window still holds
        send_item(por_pkg::FUNC_TEXT, 4'd0, por_pkg::word_t'(1), 1'b1);
        wait_drained();
        if (mismatches == 0 && kept_words_due.size() == 0)
            $display("pattern_occurrence_remover_core_tb passed");
        else
            $display("pattern_occurrence_remover_core_tb failed");
        $finish;
    end

endmodule
